// ===== design/ipd_pkg.sv =====
// Shared types, constants and codes for the I/Q datagram deframer.
package ipd_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDR0_A = 8'hA4;
    localparam logic [7:0] HDR0_B = 8'h84;
    localparam logic [7:0] HDR1_A = 8'h85;
    localparam logic [7:0] HDR1_B = 8'h81;

    localparam logic [15:0] SEQ_LAST       = 16'hFFFF;
    localparam logic [15:0] SEQ_AFTER_WRAP = 16'd1;
    localparam logic [7:0]  SPG_RESET      = 8'd240;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_SEQ    = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [23:0] i_value;
        logic signed [23:0] q_value;
        logic [15:0]        received_seq;
        logic [15:0]        expected_seq;
        logic [15:0]        seq_diff;
        logic               seq_ahead;
    } t_cmd;

endpackage

// ===== design/ipd_front.sv =====
// Front end: header check, sequence tracking and sample assembly per item.
module ipd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_push,
    output ipd_pkg::t_cmd o_cmd
);

    logic [ipd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0]               r_exp, n_exp;
    logic                      r_bad, n_bad;
    logic [7:0]                r_seq_lo, n_seq_lo;
    logic [39:0]               r_sb, n_sb;
    logic [2:0]                r_gp, n_gp;

    logic                      push;
    ipd_pkg::t_cmd             cmd;
    logic [15:0]               seq;
    logic                      in_range;

    always_comb begin
        n_pos    = r_pos;
        n_exp    = r_exp;
        n_bad    = r_bad;
        n_seq_lo = r_seq_lo;
        n_sb     = r_sb;
        n_gp     = r_gp;
        push     = 1'b0;
        cmd      = '0;
        seq      = {i_data_byte, r_seq_lo};
        in_range = r_pos < ipd_pkg::POS_W'(ipd_pkg::MAX_PACKET_BYTES);

        if (in_range) begin
            if (r_pos == ipd_pkg::POS_W'(0)) begin
                if (i_data_byte != ipd_pkg::HDR0_A && i_data_byte != ipd_pkg::HDR0_B)
                    n_bad = 1'b1;
            end else if (r_pos == ipd_pkg::POS_W'(1)) begin
                if (i_data_byte != ipd_pkg::HDR1_A && i_data_byte != ipd_pkg::HDR1_B)
                    n_bad = 1'b1;
            end else if (r_pos == ipd_pkg::POS_W'(2)) begin
                n_seq_lo = i_data_byte;
            end else if (!r_bad) begin
                if (r_pos == ipd_pkg::POS_W'(3)) begin
                    if (seq != r_exp) begin
                        push              = 1'b1;
                        cmd.kind          = ipd_pkg::KIND_SEQ;
                        cmd.received_seq  = seq;
                        cmd.expected_seq  = r_exp;
                        cmd.seq_diff      = seq - r_exp;
                        cmd.seq_ahead     = seq > r_exp;
                    end
                    n_exp = (seq == ipd_pkg::SEQ_LAST) ? ipd_pkg::SEQ_AFTER_WRAP
                                                       : seq + 16'd1;
                end else if (r_gp < 3'd5) begin
                    n_sb[8*r_gp +: 8] = i_data_byte;
                    n_gp              = r_gp + 3'd1;
                end else begin
                    push        = 1'b1;
                    cmd.kind    = ipd_pkg::KIND_SAMPLE;
                    cmd.i_value = r_sb[23:0];
                    cmd.q_value = {i_data_byte, r_sb[39:24]};
                    n_sb        = '0;
                    n_gp        = 3'd0;
                end
            end
        end

        if (i_last_byte) begin
            if (n_bad || r_pos < ipd_pkg::POS_W'(3)) begin
                push     = 1'b1;
                cmd      = '0;
                cmd.kind = ipd_pkg::KIND_BAD;
            end
            n_pos    = '0;
            n_bad    = 1'b0;
            n_seq_lo = '0;
            n_sb     = '0;
            n_gp     = 3'd0;
        end else if (in_range) begin
            n_pos = r_pos + ipd_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_exp    <= '0;
            r_bad    <= 1'b0;
            r_seq_lo <= '0;
            r_sb     <= '0;
            r_gp     <= 3'd0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_exp    <= n_exp;
            r_bad    <= n_bad;
            r_seq_lo <= n_seq_lo;
            r_sb     <= n_sb;
            r_gp     <= n_gp;
        end
    end

    assign o_push = i_accept && push;
    assign o_cmd  = cmd;

endmodule

// ===== design/ipd_queue.sv =====
// Short command queue between the front end and the back end.
module ipd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ipd_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output ipd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    ipd_pkg::t_cmd              r_mem [ipd_pkg::QUEUE_DEPTH];
    logic [ipd_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [ipd_pkg::QCNT_W-1:0] r_count;
    logic                       do_pop;

    localparam logic [ipd_pkg::QPTR_W-1:0] PTR_LAST =
        ipd_pkg::QPTR_W'(ipd_pkg::QUEUE_DEPTH - 1);

    assign o_ready = r_count < ipd_pkg::QCNT_W'(ipd_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push)
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + ipd_pkg::QPTR_W'(1);
            if (do_pop)
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + ipd_pkg::QPTR_W'(1);
            if (i_push && !do_pop)
                r_count <= r_count + ipd_pkg::QCNT_W'(1);
            else if (!i_push && do_pop)
                r_count <= r_count - ipd_pkg::QCNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready || do_pop)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ipd_pkg::QCNT_W'(ipd_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !do_pop |=> r_count == $past(r_count) + ipd_pkg::QCNT_W'(1))
        else $error("queue count did not follow push");

endmodule

// ===== design/ipd_back.sv =====
// Back end: missing-sample product, gap register and output register.
module ipd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_cmd_valid,
    input  ipd_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic signed [23:0] o_i_value,
    output logic signed [23:0] o_q_value,
    output logic [15:0]        o_received_seq,
    output logic [15:0]        o_expected_seq_out,
    output logic [23:0]        o_missing_samples
);

    logic [7:0]         r_spg;
    logic               r_valid;
    logic [1:0]         r_kind;
    logic signed [23:0] r_i, r_q;
    logic [15:0]        r_rs, r_es;
    logic [23:0]        r_miss;
    logic [23:0]        miss;

    assign o_pop = i_cmd_valid && (!r_valid || i_ready);
    assign miss  = i_cmd.seq_ahead ? 24'(r_spg) * 24'(i_cmd.seq_diff) : 24'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spg   <= ipd_pkg::SPG_RESET;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en)
                r_spg <= i_cfg_wr_data;
            if (o_pop)
                r_valid <= 1'b1;
            else if (i_ready)
                r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_cmd.kind;
            r_i    <= i_cmd.i_value;
            r_q    <= i_cmd.q_value;
            r_rs   <= i_cmd.received_seq;
            r_es   <= i_cmd.expected_seq;
            r_miss <= miss;
        end
    end

    assign o_valid            = r_valid;
    assign o_kind             = r_kind;
    assign o_i_value          = r_i;
    assign o_q_value          = r_q;
    assign o_received_seq     = r_rs;
    assign o_expected_seq_out = r_es;
    assign o_missing_samples  = r_miss;

endmodule

// ===== design/iq_packet_deframer.sv =====
// Top level of the I/Q datagram deframer: front end, command queue, back end.
// Throughput: one byte item per cycle unless the four-entry queue is full; it absorbs output stalls.
// A result passes through the queue and then the back-end output register before it is on o_valid.
// The front end writes the queue at the accept edge; the back end registers the 8x16 product.
// Reset (synchronous, active low): expected sequence 0, gap count 240, datagram state cleared.
// o_ready falls only when the queue holds four items.
module iq_packet_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_kind,
    output logic signed [23:0] o_i_value,
    output logic signed [23:0] o_q_value,
    output logic [15:0]        o_received_seq,
    output logic [15:0]        o_expected_seq_out,
    output logic [23:0]        o_missing_samples
);

    logic          accept;
    logic          push;
    ipd_pkg::t_cmd front_cmd;
    logic          q_valid;
    ipd_pkg::t_cmd q_cmd;
    logic          pop;

    assign accept = i_valid && o_ready;

    ipd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    ipd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (o_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    ipd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_cmd_valid        (q_valid),
        .i_cmd              (q_cmd),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_i_value          (o_i_value),
        .o_q_value          (o_q_value),
        .o_received_seq     (o_received_seq),
        .o_expected_seq_out (o_expected_seq_out),
        .o_missing_samples  (o_missing_samples)
    );

endmodule
